/* design/lennard_jones_pair_evaluator_core_defines.svh */
// Assertion macros for the Lennard-Jones pair evaluator.
// Needs a clk and an arst_n in the scope of each use.
`ifndef LENNARD_JONES_PAIR_EVALUATOR_CORE_DEFINES_SVH
`define LENNARD_JONES_PAIR_EVALUATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LJP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ljp assertion failed");

// next-cycle implication
`define LJP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ljp assertion failed");

`else

`define LJP_ASSERT_IMPLY(lbl, ante, cons)
`define LJP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/ljp_pkg.sv */
// Shared types, codes and helper functions of the Lennard-Jones pair evaluator.
// No dependencies.
package ljp_pkg;

	typedef enum logic [1:0] {
		K_ENERGY = 2'd0,
		K_FWD    = 2'd1,
		K_CEN    = 2'd2,
		K_FORCE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIST = 2'd1,
		ST_STEP = 2'd2,
		ST_SAT  = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_SIGMA   = 1'b0,
		REG_EPSILON = 1'b1
	} reg_idx_t;

	localparam logic [31:0] SIGMA_RST = 32'd49509565;
	localparam logic [31:0] EPS_RST   = 32'd88751473;
	localparam logic [47:0] POS_MAX   = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MAX   = 48'h8000_0000_0000;
	// largest product that still fits 64 bits after the force scale of 12
	localparam logic [63:0] P12_MAX   = 64'h1555_5555_5555_5555;

	// energy or force term of one lane, sign and magnitude in Q.32
	typedef struct packed {
		logic        pov;   // a power of sigma/R overflowed
		logic        mov;   // epsilon product or magnitude check overflowed
		logic        neg;
		logic [63:0] mag;
	} lane_res_t;

	typedef struct packed {
		kind_t   kind;
		status_t pst;       // status from the operand checks
	} meta_t;

	typedef struct packed {
		logic [47:0] val;
		status_t     st;
	} out_t;

	function automatic out_t sat_out(logic neg);
		out_t o;
		o.val = neg ? NEG_MAX : POS_MAX;
		o.st  = ST_SAT;
		return o;
	endfunction

	// sign-magnitude to two's complement with saturation
	function automatic out_t emit_sm(logic neg, logic [63:0] mag);
		out_t        o;
		logic [63:0] nmag;
		nmag = 64'd0 - mag;
		if (neg && (mag > {16'd0, NEG_MAX})) begin
			o = sat_out(1'b1);
		end else if (!neg && (mag > {16'd0, POS_MAX})) begin
			o = sat_out(1'b0);
		end else begin
			o.val = neg ? nmag[47:0] : mag[47:0];
			o.st  = ST_OK;
		end
		return o;
	endfunction

endpackage

/* design/lennard_jones_pair_evaluator_core.sv */
// Top level of the Lennard-Jones 12-6 pair evaluator: operand checks, two lanes,
// difference or force combine, final divide. Uses ljp_pkg, ljp_lane, ljp_qdiv.
//
//  channel | signals                            | transfer when
//  --------+------------------------------------+-------------------------
//  input   | in_valid/in_ready, kind, distance, | in_valid && in_ready
//          | step                               |
//  result  | out_valid/out_ready, value, status | out_valid && out_ready
//  config  | cfg_valid/cfg_ready, cfg_index,    | cfg_valid (always ready)
//          | cfg_data                           |
//
// One item may be taken every cycle; each result passes through the 64-stage
// reciprocal divider in each lane and then through the 47-stage final
// divider. All stages advance together; while a result waits at the output the
// whole pipeline holds and in_ready is low. Reset empties the pipeline and
// restores sigma and epsilon; no clearing pass is needed.
`include "lennard_jones_pair_evaluator_core_defines.svh"

module lennard_jones_pair_evaluator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] distance,
	input  logic [31:0] step,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] value,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ljp_pkg::*;

	localparam int MW = $bits(meta_t);
	localparam int OW = $bits(out_t) + 2;

	logic        adv;
	logic [31:0] sigma_q, epsilon_q;

	// whole pipeline moves unless a finished result is waiting
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q   <= SIGMA_RST;
			epsilon_q <= EPS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIGMA:   sigma_q   <= cfg_data;
				REG_EPSILON: epsilon_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// stage 1: operand checks and lane distances
	kind_t       k_in;
	logic        is_diff;
	meta_t       meta_c;
	logic [32:0] ra_c, rb_c;
	logic [33:0] dsr_c;

	assign k_in = kind_t'(kind);

	always_comb begin
		is_diff     = (k_in == K_FWD) || (k_in == K_CEN);
		meta_c.kind = k_in;
		meta_c.pst  = ST_OK;
		if (distance == 32'd0) begin
			meta_c.pst = ST_DIST;
		end else if (is_diff && (step == 32'd0)) begin
			meta_c.pst = ST_STEP;
		end else if ((k_in == K_CEN) && (step >= distance)) begin
			meta_c.pst = ST_DIST;
		end
		ra_c = is_diff ? ({1'b0, distance} + {1'b0, step}) : {1'b0, distance};
		rb_c = (k_in == K_CEN) ? ({1'b0, distance} - {1'b0, step}) : {1'b0, distance};
		case (k_in)
			K_FWD:   dsr_c = {2'b00, step};
			K_CEN:   dsr_c = {1'b0, step, 1'b0};
			default: dsr_c = {2'b00, distance};
		endcase
	end

	logic        pre_vld_s1;
	meta_t       pre_meta_s1;
	logic [32:0] pre_ra_s1, pre_rb_s1;
	logic [33:0] pre_dsr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s1 <= 1'b0;
		end else if (adv) begin
			pre_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_meta_s1 <= meta_c;
			pre_ra_s1   <= ra_c;
			pre_rb_s1   <= rb_c;
			pre_dsr_s1  <= dsr_c;
		end
	end

	// lane A: E(R) or E(R+h) or the force term; lane B: E(R) or E(R-h)
	logic        la_vld, lb_vld;
	lane_res_t   la_res, lb_res;
	logic [MW-1:0] la_pass;
	logic [33:0] lb_dsr;
	meta_t       la_meta;

	ljp_lane #(.PW(MW)) u_lane_a (
		.clk, .arst_n, .en(adv), .vld(pre_vld_s1),
		.frc(pre_meta_s1.kind == K_FORCE), .r(pre_ra_s1),
		.sigma(sigma_q), .epsilon(epsilon_q), .pass(pre_meta_s1),
		.vld_o(la_vld), .res(la_res), .pass_o(la_pass)
	);

	ljp_lane #(.PW(34)) u_lane_b (
		.clk, .arst_n, .en(adv), .vld(pre_vld_s1),
		.frc(1'b0), .r(pre_rb_s1),
		.sigma(sigma_q), .epsilon(epsilon_q), .pass(pre_dsr_s1),
		.vld_o(lb_vld), .res(lb_res), .pass_o(lb_dsr)
	);

	assign la_meta = meta_t'(la_pass);

	// combine: settle early outcomes, else form the dividend
	logic        ova, ovb, d_neg;
	logic [63:0] d_mag, p12;
	logic        fin_c, neg_c;
	out_t        out_c;
	logic [63:0] num_c;

	always_comb begin
		ova = la_res.pov | la_res.mov;
		ovb = lb_res.pov | lb_res.mov;
		if (la_res.neg != lb_res.neg) begin
			d_neg = la_res.neg;
			d_mag = la_res.mag + lb_res.mag;
		end else if (la_res.mag >= lb_res.mag) begin
			d_neg = la_res.neg;
			d_mag = la_res.mag - lb_res.mag;
		end else begin
			d_neg = !la_res.neg;
			d_mag = lb_res.mag - la_res.mag;
		end
		if (d_mag == 64'd0) begin
			d_neg = 1'b0;
		end
		p12 = {la_res.mag[60:0], 3'b000} + {la_res.mag[61:0], 2'b00};

		fin_c      = 1'b1;
		out_c.val  = '0;
		out_c.st   = la_meta.pst;
		neg_c      = 1'b0;
		num_c      = '0;
		if (la_meta.pst == ST_OK) begin
			case (la_meta.kind)
				K_ENERGY: begin
					out_c = ova ? sat_out(1'b0) : emit_sm(la_res.neg, {8'd0, la_res.mag[63:8]});
				end
				K_FWD, K_CEN: begin
					if (ova || ovb) begin
						out_c = sat_out(1'b1);
					end else begin
						fin_c = 1'b0;
						neg_c = d_neg;
						num_c = d_mag;
					end
				end
				K_FORCE: begin
					if (la_res.pov) begin
						out_c = sat_out(1'b0);
					end else if (la_res.mov) begin
						out_c = sat_out(la_res.neg);
					end else begin
						fin_c = 1'b0;
						neg_c = la_res.neg;
						num_c = p12;
					end
				end
				default: ;
			endcase
		end
	end

	logic        cmb_vld_s2, cmb_fin_s2, cmb_neg_s2;
	out_t        cmb_out_s2;
	logic [63:0] cmb_num_s2;
	logic [33:0] cmb_dsr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmb_vld_s2 <= 1'b0;
		end else if (adv) begin
			cmb_vld_s2 <= la_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmb_fin_s2 <= fin_c;
			cmb_out_s2 <= out_c;
			cmb_neg_s2 <= neg_c;
			cmb_num_s2 <= num_c;
			cmb_dsr_s2 <= lb_dsr;
		end
	end

	// final divide by h, 2h or R into Q24.24
	logic          qd_vld, qd_ovf;
	logic [46:0]   qd_quo;
	logic [OW-1:0] qd_pass;
	logic          qd_fin, qd_neg;
	out_t          qd_out, res_c;

	ljp_qdiv #(.PW(OW)) u_qdiv (
		.clk, .arst_n, .en(adv), .vld(cmb_vld_s2),
		.num(cmb_num_s2), .dsr(cmb_dsr_s2),
		.pass({cmb_fin_s2, cmb_out_s2, cmb_neg_s2}),
		.vld_o(qd_vld), .quo(qd_quo), .ovf(qd_ovf), .pass_o(qd_pass)
	);

	assign qd_fin = qd_pass[OW-1];
	assign qd_out = out_t'(qd_pass[OW-2:1]);
	assign qd_neg = qd_pass[0];

	always_comb begin
		if (qd_fin) begin
			res_c = qd_out;
		end else if (qd_ovf) begin
			res_c = sat_out(qd_neg);
		end else begin
			res_c = emit_sm(qd_neg, {17'd0, qd_quo});
		end
	end

	// output register
	logic out_valid_q;
	out_t out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= qd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = out_res_q.val;
	assign status    = out_res_q.st;

	// checks
	logic out_err, out_sat;

	assign out_err = out_valid_q && (out_res_q.st == ST_DIST || out_res_q.st == ST_STEP);
	assign out_sat = out_valid_q && (out_res_q.st == ST_SAT);

	`LJP_ASSERT_IMPLY(a_lane_lockstep, la_vld || lb_vld, la_vld && lb_vld)
	`LJP_ASSERT_IMPLY(a_err_zero, out_err, out_res_q.val == 48'd0)
	`LJP_ASSERT_IMPLY(a_sat_rail, out_sat, out_res_q.val == POS_MAX || out_res_q.val == NEG_MAX)
	`LJP_ASSERT_NEXT(a_stall_hold, qd_vld && !adv, qd_vld)

endmodule

/* design/ljp_mul.sv */
// Two-stage 64x64 multiplier returning (a*b) >> SH with an overflow flag.
// Uses ljp_pkg; carries a side vector alongside the product.
module ljp_mul #(
	parameter int SH = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	input  logic [PW-1:0] pass,
	output logic          vld_o,
	output logic [63:0]   y,
	output logic          ovf,
	output logic [PW-1:0] pass_o
);
	import ljp_pkg::*;

	logic [63:0]   pll_s1, plh_s1, phl_s1, phh_s1;
	logic          vld_s1;
	logic [PW-1:0] pass_s1;
	logic [127:0]  prod;

	// stage 1: 32x32 partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_o  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1  <= a[31:0] * b[31:0];
			plh_s1  <= a[31:0] * b[63:32];
			phl_s1  <= a[63:32] * b[31:0];
			phh_s1  <= a[63:32] * b[63:32];
			pass_s1 <= pass;
		end
	end

	// stage 2: sum, shift and range check
	assign prod = {phh_s1, pll_s1} + {32'd0, plh_s1, 32'd0} + {32'd0, phl_s1, 32'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			y      <= prod[SH+63:SH];
			ovf    <= |prod[127:SH+64];
			pass_o <= pass_s1;
		end
	end

endmodule

/* design/ljp_recip.sv */
// Pipelined restoring divider for x = (sigma << 32) / R, one quotient bit a stage.
// Uses ljp_pkg; sigma must be stable while items are in flight.
module ljp_recip #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [31:0]   num_hi,
	input  logic [32:0]   dsr,
	input  logic [PW-1:0] pass,
	output logic          vld_o,
	output logic [63:0]   quo,
	output logic [PW-1:0] pass_o
);
	import ljp_pkg::*;

	localparam int QW = 64;

	logic          vld_s  [QW+1];
	logic [32:0]   rem_s  [QW+1];
	logic [63:0]   quo_s  [QW+1];
	logic [32:0]   dsr_s  [QW+1];
	logic [PW-1:0] pass_s [QW+1];
	logic [32:0]   nxt_rem [QW+1];
	logic [63:0]   nxt_quo [QW+1];

	// one trial subtraction per stage; numerator bits below 32 are zero
	always_comb begin
		int          j;
		logic        nb;
		logic        ge;
		logic [33:0] t;
		logic [33:0] dif;
		nxt_rem[0] = '0;
		nxt_quo[0] = '0;
		for (int k = 1; k <= QW; k++) begin
			j  = QW - k;
			nb = 1'b0;
			if (j >= 32) begin
				nb = num_hi[j-32];
			end
			t   = {rem_s[k-1], nb};
			dif = t - {1'b0, dsr_s[k-1]};
			ge  = (t >= {1'b0, dsr_s[k-1]});
			nxt_rem[k] = ge ? dif[32:0] : t[32:0];
			nxt_quo[k] = {quo_s[k-1][62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld;
			for (int k = 1; k <= QW; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
			dsr_s[0]  <= dsr;
			pass_s[0] <= pass;
			for (int k = 1; k <= QW; k++) begin
				rem_s[k]  <= nxt_rem[k];
				quo_s[k]  <= nxt_quo[k];
				dsr_s[k]  <= dsr_s[k-1];
				pass_s[k] <= pass_s[k-1];
			end
		end
	end

	assign vld_o  = vld_s[QW];
	assign quo    = quo_s[QW];
	assign pass_o = pass_s[QW];

endmodule

/* design/ljp_qdiv.sv */
// Pipelined divider for (num << 16) / dsr, 47 quotient bits, overflow flagged.
// Uses ljp_pkg; one quotient bit a stage after a range-check stage.
module ljp_qdiv #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [63:0]   num,
	input  logic [33:0]   dsr,
	input  logic [PW-1:0] pass,
	output logic          vld_o,
	output logic [46:0]   quo,
	output logic          ovf,
	output logic [PW-1:0] pass_o
);
	import ljp_pkg::*;

	localparam int QW = 47;

	logic          vld_s  [QW+1];
	logic [33:0]   rem_s  [QW+1];
	logic [30:0]   low_s  [QW+1];
	logic [46:0]   quo_s  [QW+1];
	logic [33:0]   dsr_s  [QW+1];
	logic          ovf_s  [QW+1];
	logic [PW-1:0] pass_s [QW+1];
	logic [33:0]   nxt_rem [QW+1];
	logic [46:0]   nxt_quo [QW+1];

	// trial subtraction; the dividend's low 16 bits are zero
	always_comb begin
		int          i;
		logic        nb;
		logic        ge;
		logic [34:0] t;
		logic [34:0] dif;
		nxt_rem[0] = '0;
		nxt_quo[0] = '0;
		for (int k = 1; k <= QW; k++) begin
			i  = QW - k;
			nb = 1'b0;
			if (i >= 16) begin
				nb = low_s[k-1][i-16];
			end
			t   = {rem_s[k-1], nb};
			dif = t - {1'b0, dsr_s[k-1]};
			ge  = (t >= {1'b0, dsr_s[k-1]});
			nxt_rem[k] = ge ? dif[33:0] : t[33:0];
			nxt_quo[k] = {quo_s[k-1][45:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld;
			for (int k = 1; k <= QW; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// range check: quotient fits 47 bits only if num >> 31 is below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {1'b0, num[63:31]};
			low_s[0]  <= num[30:0];
			quo_s[0]  <= '0;
			dsr_s[0]  <= dsr;
			ovf_s[0]  <= ({1'b0, num[63:31]} >= dsr);
			pass_s[0] <= pass;
			for (int k = 1; k <= QW; k++) begin
				rem_s[k]  <= nxt_rem[k];
				low_s[k]  <= low_s[k-1];
				quo_s[k]  <= nxt_quo[k];
				dsr_s[k]  <= dsr_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				pass_s[k] <= pass_s[k-1];
			end
		end
	end

	assign vld_o  = vld_s[QW];
	assign quo    = quo_s[QW];
	assign ovf    = ovf_s[QW];
	assign pass_o = pass_s[QW];

endmodule

/* design/ljp_lane.sv */
// One evaluation lane: sigma/R, its powers up to 12, and the epsilon-scaled term.
// Uses ljp_pkg, ljp_recip and ljp_mul.
module ljp_lane #(
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  logic                frc,
	input  logic [32:0]         r,
	input  logic [31:0]         sigma,
	input  logic [31:0]         epsilon,
	input  logic [PW-1:0]       pass,
	output logic                vld_o,
	output ljp_pkg::lane_res_t  res,
	output logic [PW-1:0]       pass_o
);
	import ljp_pkg::*;

	logic          v1, v2, v3, v4, v5, v6;
	logic [63:0]   x, x2, x4, x6, x12, p;
	logic          ov1, ov2, ov3, ov4, ov5;
	logic [PW:0]   p1, p2;
	logic [PW+65:0] p3, p5;
	logic [PW+1:0] p4;
	logic [PW+2:0] p6;

	// x = sigma / R in Q32.32
	ljp_recip #(.PW(PW+1)) u_recip (
		.clk, .arst_n, .en, .vld,
		.num_hi(sigma), .dsr(r), .pass({frc, pass}),
		.vld_o(v1), .quo(x), .pass_o(p1)
	);

	// x^2
	ljp_mul #(.SH(32), .PW(PW+1)) u_x2 (
		.clk, .arst_n, .en, .vld(v1), .a(x), .b(x), .pass(p1),
		.vld_o(v2), .y(x2), .ovf(ov1), .pass_o(p2)
	);

	// x^4, keeping x^2 for the next product
	ljp_mul #(.SH(32), .PW(PW+66)) u_x4 (
		.clk, .arst_n, .en, .vld(v2), .a(x2), .b(x2), .pass({ov1, p2, x2}),
		.vld_o(v3), .y(x4), .ovf(ov2), .pass_o(p3)
	);

	// x^6
	ljp_mul #(.SH(32), .PW(PW+2)) u_x6 (
		.clk, .arst_n, .en, .vld(v3), .a(x4), .b(p3[63:0]),
		.pass({p3[PW+65] | ov2, p3[PW+64:64]}),
		.vld_o(v4), .y(x6), .ovf(ov3), .pass_o(p4)
	);

	// x^12, keeping x^6
	ljp_mul #(.SH(32), .PW(PW+66)) u_x12 (
		.clk, .arst_n, .en, .vld(v4), .a(x6), .b(x6),
		.pass({p4[PW+1] | ov3, p4[PW:0], x6}),
		.vld_o(v5), .y(x12), .ovf(ov4), .pass_o(p5)
	);

	// difference term: x^12 - 2x^6 for energy, x^12 - x^6 for force
	logic          sm_vld_s1, sm_neg_s1, sm_pov_s1, sm_frc_s1;
	logic [63:0]   sm_m_s1;
	logic [PW-1:0] sm_pass_s1;
	logic [63:0]   x6c, sub_v;
	logic          frc5, neg5;

	assign x6c   = p5[63:0];
	assign frc5  = p5[PW+64];
	assign sub_v = frc5 ? x6c : {x6c[62:0], 1'b0};
	assign neg5  = x12 < sub_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_vld_s1 <= 1'b0;
		end else if (en) begin
			sm_vld_s1 <= v5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_m_s1    <= neg5 ? (sub_v - x12) : (x12 - sub_v);
			sm_neg_s1  <= neg5;
			sm_pov_s1  <= p5[PW+65] | ov4;
			sm_frc_s1  <= frc5;
			sm_pass_s1 <= p5[PW+63:64];
		end
	end

	// scale by epsilon, Q.32 result
	ljp_mul #(.SH(24), .PW(PW+3)) u_eps (
		.clk, .arst_n, .en, .vld(sm_vld_s1), .a(sm_m_s1), .b({32'd0, epsilon}),
		.pass({sm_frc_s1, sm_pov_s1, sm_neg_s1, sm_pass_s1}),
		.vld_o(v6), .y(p), .ovf(ov5), .pass_o(p6)
	);

	// range checks: energy below 2^63, force term still fits after scaling by 12
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= v6;
		end
	end

	// sign kept on overflow so a saturated force takes the term's sign
	always_ff @(posedge clk) begin
		if (en) begin
			res.pov <= p6[PW+1];
			res.mov <= ov5 | (p6[PW+2] ? (p > P12_MAX) : p[63]);
			res.neg <= p6[PW] & (ov5 | (p != 64'd0));
			res.mag <= p;
			pass_o  <= p6[PW-1:0];
		end
	end

endmodule

/* test/tb.sv */
// Testbench for the Lennard-Jones 12-6 pair evaluator core: energy, difference and force.
// A scoreboard class predicts each result in fixed point; needs ljp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
	import ljp_pkg::*;

	typedef struct {
		logic [47:0] val;
		status_t     st;
	} ljp_result_t;

	// Predicts each pair result and holds them in order until they come out
	class pair_scoreboard;
		logic [31:0] sigma_q;
		logic [31:0] eps_q;
		ljp_result_t pending[$];
		int          errors;

		function new();
			sigma_q = SIGMA_RST;
			eps_q   = EPS_RST;
			errors  = 0;
		endfunction

		// (a*b) >> sh; returns 0, with res all ones, when the result does not fit 64 bits
		function bit mul_shift(logic [63:0] a, logic [63:0] b, int sh, output logic [63:0] res);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			res = '1;
			if ((p >> (64 + sh)) != 0)
				return 0;
			res = 64'(p >> sh);
			return 1;
		endfunction

		function bit ratio_powers(logic [31:0] r, output logic [63:0] x6, output logic [63:0] x12);
			logic [63:0] x, x2, x4;
			x6  = '0;
			x12 = '0;
			x = {sigma_q, 32'd0} / {32'd0, r};
			if (!mul_shift(x, x, 32, x2)) return 0;
			if (!mul_shift(x2, x2, 32, x4)) return 0;
			if (!mul_shift(x4, x2, 32, x6)) return 0;
			if (!mul_shift(x6, x6, 32, x12)) return 0;
			return 1;
		endfunction

		// energy in Q.32 sign and magnitude
		function bit pair_energy(logic [32:0] r, output bit neg, output logic [63:0] mag);
			logic [63:0] x6, x12, two6, m;
			neg = 0;
			mag = '0;
			if (r[32]) begin
				// distance beyond 32 bits: ratio computed on the full width
				logic [63:0] x, x2, x4;
				x = {sigma_q, 32'd0} / {31'd0, r};
				if (!mul_shift(x, x, 32, x2)) return 0;
				if (!mul_shift(x2, x2, 32, x4)) return 0;
				if (!mul_shift(x4, x2, 32, x6)) return 0;
				if (!mul_shift(x6, x6, 32, x12)) return 0;
			end else if (!ratio_powers(r[31:0], x6, x12)) begin
				return 0;
			end
			two6 = x6 << 1;
			neg = x12 < two6;
			m = neg ? two6 - x12 : x12 - two6;
			if (!mul_shift(m, {32'd0, eps_q}, 24, mag)) return 0;
			if (mag[63]) return 0;
			if (mag == 0) neg = 0;
			return 1;
		endfunction

		function bit div_q16(logic [63:0] mag, logic [63:0] d, output logic [63:0] q);
			logic [63:0] q1, rem;
			q1  = mag / d;
			rem = mag % d;
			q   = '0;
			if (q1 >= 64'h8000_0000) return 0;
			q = (q1 << 16) + ((rem << 16) / d);
			return 1;
		endfunction

		function ljp_result_t saturate(bit neg);
			ljp_result_t o;
			o.val = neg ? NEG_MAX : POS_MAX;
			o.st  = ST_SAT;
			return o;
		endfunction

		function ljp_result_t signed_out(bit neg, logic [63:0] mag);
			ljp_result_t o;
			logic [63:0]  n;
			if (neg && mag > {16'd0, NEG_MAX}) return saturate(1);
			if (!neg && mag > {16'd0, POS_MAX}) return saturate(0);
			n = 64'd0 - mag;
			o.val = neg ? n[47:0] : mag[47:0];
			o.st  = ST_OK;
			return o;
		endfunction

		function ljp_result_t predict(kind_t k, logic [31:0] r, logic [31:0] h);
			ljp_result_t o;
			bit          an, bn, dn;
			logic [63:0] am, bm, dm, q, x6, x12, m, p;
			logic [32:0] lo, hi;
			logic [63:0] dv;
			o.val = '0;
			if (r == 0) begin
				o.st = ST_DIST;
				return o;
			end
			if ((k == K_FWD || k == K_CEN) && h == 0) begin
				o.st = ST_STEP;
				return o;
			end
			if (k == K_CEN && h >= r) begin
				o.st = ST_DIST;
				return o;
			end
			case (k)
				K_ENERGY: begin
					if (!pair_energy({1'b0, r}, an, am)) return saturate(0);
					return signed_out(an, am >> 8);
				end
				K_FWD, K_CEN: begin
					hi = {1'b0, r} + {1'b0, h};
					lo = (k == K_FWD) ? {1'b0, r} : {1'b0, r - h};
					dv = (k == K_FWD) ? {32'd0, h} : {31'd0, h, 1'b0};
					if (!pair_energy(hi, an, am) || !pair_energy(lo, bn, bm))
						return saturate(1);
					// a - b in sign and magnitude
					if (an != bn) begin
						dn = an;
						dm = am + bm;
					end else if (am >= bm) begin
						dn = an;
						dm = am - bm;
					end else begin
						dn = !an;
						dm = bm - am;
					end
					if (dm == 0) dn = 0;
					if (!div_q16(dm, dv, q)) return saturate(dn);
					return signed_out(dn, q);
				end
				default: begin
					if (!ratio_powers(r, x6, x12)) return saturate(0);
					dn = x12 < x6;
					m = dn ? x6 - x12 : x12 - x6;
					if (!mul_shift(m, {32'd0, eps_q}, 24, p)) return saturate(dn);
					if (p > 64'hFFFF_FFFF_FFFF_FFFF / 12) return saturate(dn);
					p = p * 12;
					if (!div_q16(p, {32'd0, r}, q)) return saturate(dn);
					if (q == 0) dn = 0;
					return signed_out(dn, q);
				end
			endcase
		endfunction

		function void note_pair(kind_t k, logic [31:0] r, logic [31:0] h);
			pending.push_back(predict(k, r, h));
		endfunction

		function void check_result(logic [47:0] v, logic [1:0] s);
			ljp_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result value=%h status=%0d", v, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.val) begin
				$error("value: expected %h, actual %h", e.val, v);
				errors++;
			end
			if (s !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, s);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [31:0] distance;
	logic [31:0] step;
	logic        out_valid;
	logic        out_ready;
	logic [47:0] value;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	pair_scoreboard sb;
	bit             calm;
	int unsigned    cycles;

	lennard_jones_pair_evaluator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .distance(distance), .step(step),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// transfer monitor on the input and result channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pair(kind_t'(kind), distance, step);
			if (out_valid && out_ready)
				sb.check_result(value, status);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				out_ready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic send_pair(kind_t k, logic [31:0] r, logic [31:0] h);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid = 1'b1;
		kind     = k;
		distance = r;
		step     = h;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		in_valid  = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_SIGMA)
			sb.sigma_q = d;
		else
			sb.eps_q = d;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (140) @(negedge clk);
	endtask

	task automatic random_pairs(int count);
		kind_t       k;
		logic [31:0] r, h;
		int          sel;
		repeat (count) begin
			k = kind_t'($urandom_range(0, 3));
			sel = $urandom_range(0, 99);
			if (sel < 65)
				r = $urandom_range(32'h0100_0000, 32'h0A00_0000);
			else if (sel < 85)
				r = $urandom;
			else
				r = $urandom_range(0, 32'h0080_0000);
			sel = $urandom_range(0, 99);
			if (sel < 70)
				h = $urandom_range(1, 32'h0010_0000);
			else if (sel < 85)
				h = $urandom;
			else
				h = $urandom_range(0, 3);
			send_pair(k, r, h);
		end
	endtask

	initial begin
		sb        = new();
		calm      = 0;
		cycles    = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = K_ENERGY;
		distance  = '0;
		step      = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SIGMA;
		cfg_data  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero distance, zero step, step not below distance
		send_pair(K_ENERGY, 32'd0, 32'd5);
		send_pair(K_FWD, 32'd0, 32'd0);
		send_pair(K_CEN, 32'd0, 32'd7);
		send_pair(K_FORCE, 32'd0, 32'd0);
		send_pair(K_FWD, 32'h0300_0000, 32'd0);
		send_pair(K_CEN, 32'h0300_0000, 32'd0);
		send_pair(K_CEN, 32'h0300_0000, 32'h0300_0000);
		send_pair(K_CEN, 32'h0300_0000, 32'hFFFF_FFFF);
		// power overflow at tiny distance
		send_pair(K_ENERGY, 32'd1, 32'd1);
		send_pair(K_FWD, 32'd1, 32'd1);
		send_pair(K_CEN, 32'd2, 32'd1);
		send_pair(K_FORCE, 32'd1, 32'd0);
		// largest distance and step
		send_pair(K_ENERGY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(K_FWD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(K_CEN, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_pair(K_FORCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// around the well and the zero crossing
		send_pair(K_ENERGY, 32'h0350_0000, 32'd1);
		send_pair(K_ENERGY, 32'h02F3_0000, 32'd1);
		send_pair(K_FWD, 32'h0350_0000, 32'd1);
		send_pair(K_CEN, 32'h0350_0000, 32'h0001_0000);
		send_pair(K_FORCE, 32'h0350_0000, 32'd0);
		send_pair(K_FORCE, 32'h0200_0000, 32'd0);
		random_pairs(80);
		drain();

		// register extremes
		write_reg(REG_SIGMA, 32'd0);
		write_reg(REG_EPSILON, 32'hFFFF_FFFF);
		random_pairs(60);
		drain();
		write_reg(REG_SIGMA, 32'hFFFF_FFFF);
		write_reg(REG_EPSILON, 32'd0);
		random_pairs(60);
		drain();
		write_reg(REG_SIGMA, $urandom);
		write_reg(REG_EPSILON, $urandom);
		random_pairs(80);
		drain();
		write_reg(REG_SIGMA, 32'h0300_0000);
		write_reg(REG_EPSILON, 32'h0100_0000);
		random_pairs(70);
		calm = 1;
		random_pairs(60);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* lennard_jones_pair_evaluator_core.f */
+incdir+design
design/ljp_pkg.sv
design/ljp_mul.sv
design/ljp_recip.sv
design/ljp_qdiv.sv
design/ljp_lane.sv
design/lennard_jones_pair_evaluator_core.sv
test/tb.sv
